@@ hdl/sgcw_pkg.sv @@
// ----------------------------------------------------------------------------
// sgcw_pkg
// Shared constants and types of the scatter-gather chunk walker.
// ----------------------------------------------------------------------------
package sgcw_pkg;

	localparam int MAX_SEGMENTS = 16;
	localparam int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
	localparam int RESULT_CAP   = 16;
	localparam int RCNT_W       = $clog2(RESULT_CAP + 1);

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_INIT = 2'd1;
	localparam logic [1:0] REQ_XFER = 2'd2;

	typedef struct packed {
		logic [63:0] address;
		logic [31:0] length;
	} seg_entry_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		seg_entry_t       wr_data;
		logic [IDX_W-1:0] rd_idx;
	} tbl_req_t;

endpackage

@@ hdl/sgcw_table.sv @@
// ----------------------------------------------------------------------------
// sgcw_table
// Segment table: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module sgcw_table (
	input  logic                  clk,
	input  sgcw_pkg::tbl_req_t    req,
	output sgcw_pkg::seg_entry_t  rd_data
);

	sgcw_pkg::seg_entry_t mem [sgcw_pkg::MAX_SEGMENTS];
	sgcw_pkg::seg_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_idx] <= req.wr_data;
		end
		rd_data_q <= mem[req.rd_idx];
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/scatter_gather_chunk_walker_top.sv @@
// ----------------------------------------------------------------------------
// scatter_gather_chunk_walker_top
// A load item writes one segment into the table; an init item sets the
// segment count and rewinds the cursor through the fetch state. A transfer
// item walks the list chunk by chunk, passes through the fetch state each
// time the cursor moves to a new segment (the table has a single read port
// with registered read data), and closes through the finish state; a chunk
// waits while a result is stalled on the output. The last chunk of a request
// is held back in a pending register until the walk knows it is the last,
// and results leave through an output register, so a new item is taken
// while a result waits.
// ----------------------------------------------------------------------------
module scatter_gather_chunk_walker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [3:0]  seg_index,
	input  logic [63:0] seg_address,
	input  logic [31:0] seg_length,
	input  logic [4:0]  seg_count,
	input  logic [31:0] xfer_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] chunk_address,
	output logic [31:0] chunk_length,
	output logic [31:0] total_done,
	output logic        last_chunk
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_FETCH  = 2'd1;
	localparam logic [1:0] ST_WALK   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	localparam int CW = sgcw_pkg::CNT_W;
	localparam int RW = sgcw_pkg::RCNT_W;

	logic [1:0]    state_q, ret_q;
	logic [CW-1:0] cnt_q, cur_idx_q;
	logic          hit_q;
	logic [63:0]   cur_addr_q;
	logic [31:0]   cur_left_q;
	logic [31:0]   rem_q, total_q;
	logic [RW-1:0] nchunk_q;
	logic          pend_valid_q;
	logic [63:0]   pend_addr_q;
	logic [31:0]   pend_len_q, pend_total_q;
	logic          out_valid_q, out_last_q;
	logic [63:0]   out_addr_q;
	logic [31:0]   out_len_q, out_total_q;

	sgcw_pkg::tbl_req_t   tbl_req;
	sgcw_pkg::seg_entry_t tbl_rd;

	logic          in_fire, out_free, out_load;
	logic [CW-1:0] cnt_sat, step_idx;
	logic          step_hit, idx_live, walk_done, zero_piece;
	logic [31:0]   piece, left_after;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign cnt_sat = (8'(seg_count) > 8'(sgcw_pkg::MAX_SEGMENTS))
		? CW'(sgcw_pkg::MAX_SEGMENTS) : CW'(seg_count);

	assign step_idx   = cur_idx_q + CW'(1);
	assign step_hit   = (step_idx < cnt_q);
	assign idx_live   = (cur_idx_q < cnt_q);
	assign piece      = (rem_q < cur_left_q) ? rem_q : cur_left_q;
	assign left_after = cur_left_q - piece;
	assign walk_done  = (rem_q == 32'd0) || (nchunk_q == RW'(sgcw_pkg::RESULT_CAP));
	assign zero_piece = (cur_left_q == 32'd0);

	// The output register takes a new result when a held chunk moves on or
	// when a request closes.
	assign out_load = ((state_q == ST_WALK) && !walk_done && !zero_piece &&
		pend_valid_q && out_free) || ((state_q == ST_FINISH) && out_free);

	// The table is written only from idle and read only while walking or on
	// an init, so a read never meets a write to the same entry.
	always_comb begin
		tbl_req.wr_en           = in_fire && (req_type == sgcw_pkg::REQ_LOAD) &&
			(8'(seg_index) < 8'(sgcw_pkg::MAX_SEGMENTS));
		tbl_req.wr_idx          = sgcw_pkg::IDX_W'(seg_index);
		tbl_req.wr_data.address = seg_address;
		tbl_req.wr_data.length  = seg_length;
		tbl_req.rd_idx          = (state_q == ST_IDLE) ? '0
			: step_idx[sgcw_pkg::IDX_W-1:0];
	end

	sgcw_table u_table (
		.clk     (clk),
		.req     (tbl_req),
		.rd_data (tbl_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ret_q        <= ST_IDLE;
			cnt_q        <= '0;
			cur_idx_q    <= '0;
			hit_q        <= 1'b0;
			cur_addr_q   <= '0;
			cur_left_q   <= '0;
			rem_q        <= '0;
			total_q      <= '0;
			nchunk_q     <= '0;
			pend_valid_q <= 1'b0;
			pend_addr_q  <= '0;
			pend_len_q   <= '0;
			pend_total_q <= '0;
			out_valid_q  <= 1'b0;
			out_addr_q   <= '0;
			out_len_q    <= '0;
			out_total_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (req_type)
							sgcw_pkg::REQ_INIT: begin
								cnt_q     <= cnt_sat;
								cur_idx_q <= '0;
								hit_q     <= (cnt_sat != '0);
								ret_q     <= ST_IDLE;
								state_q   <= ST_FETCH;
							end
							sgcw_pkg::REQ_XFER: begin
								rem_q        <= xfer_length;
								total_q      <= '0;
								nchunk_q     <= '0;
								pend_valid_q <= 1'b0;
								state_q      <= ST_WALK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FETCH: begin
					cur_addr_q <= hit_q ? tbl_rd.address : 64'd0;
					cur_left_q <= hit_q ? tbl_rd.length : 32'd0;
					state_q    <= ret_q;
				end
				ST_WALK: begin
					if (walk_done) begin
						state_q <= ST_FINISH;
					end else if (zero_piece) begin
						// An empty segment ends the request; step past it while
						// the list lasts.
						if (idx_live) begin
							cur_idx_q <= step_idx;
							hit_q     <= step_hit;
							ret_q     <= ST_FINISH;
							state_q   <= ST_FETCH;
						end else begin
							state_q <= ST_FINISH;
						end
					end else if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							out_addr_q  <= pend_addr_q;
							out_len_q   <= pend_len_q;
							out_total_q <= pend_total_q;
							out_last_q  <= 1'b0;
						end
						pend_valid_q <= 1'b1;
						pend_addr_q  <= cur_addr_q;
						pend_len_q   <= piece;
						pend_total_q <= total_q + piece;
						total_q      <= total_q + piece;
						rem_q        <= rem_q - piece;
						nchunk_q     <= nchunk_q + RW'(1);
						if (left_after == 32'd0) begin
							cur_idx_q <= step_idx;
							hit_q     <= step_hit;
							ret_q     <= ST_WALK;
							state_q   <= ST_FETCH;
						end else begin
							cur_left_q <= left_after;
							cur_addr_q <= cur_addr_q + 64'(piece);
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_last_q  <= 1'b1;
						if (pend_valid_q) begin
							out_addr_q  <= pend_addr_q;
							out_len_q   <= pend_len_q;
							out_total_q <= pend_total_q;
						end else begin
							out_addr_q  <= cur_addr_q;
							out_len_q   <= '0;
							out_total_q <= '0;
						end
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign chunk_address = out_addr_q;
	assign chunk_length  = out_len_q;
	assign total_done    = out_total_q;
	assign last_chunk    = out_last_q;

endmodule

@@ hdl/sgcw_checker.sv @@
// ----------------------------------------------------------------------------
// sgcw_checker
// Port-level checks of the chunk walker's result channel.
// ----------------------------------------------------------------------------
module sgcw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] chunk_address,
	input logic [31:0] chunk_length,
	input logic [31:0] total_done,
	input logic        last_chunk
);

	// A stalled result keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chunk_address) &&
		$stable(chunk_length) && $stable(total_done) && $stable(last_chunk))
		else $error("result changed while stalled");

	// An empty result is always the only one of its request.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chunk_length == 32'd0 |-> last_chunk && total_done == 32'd0)
		else $error("empty result is not a lone final result");

	// The running total always covers the chunk it comes with.
	a_total_covers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chunk_length != 32'd0 |-> total_done >= chunk_length)
		else $error("total smaller than chunk");

	// After a non-final chunk is taken, the next result continues the total.
	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_chunk ##1 out_valid |->
		total_done == $past(total_done) + chunk_length)
		else $error("total does not continue across chunks");

endmodule

bind scatter_gather_chunk_walker_top sgcw_checker u_sgcw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.chunk_address (chunk_address),
	.chunk_length  (chunk_length),
	.total_done    (total_done),
	.last_chunk    (last_chunk)
);

@@ verif/scatter_gather_chunk_walker_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scatter_gather_chunk_walker_top_tb
// Self-checking bench for the chunk walker. A queue-fed driver sends segment
// loads, cursor inits and transfer requests under random gaps. An internal
// predictor walks its own copy of the table and cursor. A monitor under random
// backpressure checks every chunk against the expected chunks in order.
// ----------------------------------------------------------------------------
module scatter_gather_chunk_walker_top_tb;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT     = 2000;
	localparam int SETTLE_CYCLES      = 60;

	typedef struct {
		logic [1:0]  kind;
		logic [3:0]  idx;
		logic [63:0] addr;
		logic [31:0] len;
		logic [4:0]  cnt;
		logic [31:0] xlen;
		bit          hold;
	} walk_req_t;

	typedef struct {
		logic [63:0] addr;
		logic [31:0] len;
		logic [31:0] total;
		logic        last;
	} chunk_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = '0;
	logic [3:0]  seg_index = '0;
	logic [63:0] seg_address = '0;
	logic [31:0] seg_length = '0;
	logic [4:0]  seg_count = '0;
	logic [31:0] xfer_length = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] chunk_address;
	logic [31:0] chunk_length;
	logic [31:0] total_done;
	logic        last_chunk;

	scatter_gather_chunk_walker_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.seg_index    (seg_index),
		.seg_address  (seg_address),
		.seg_length   (seg_length),
		.seg_count    (seg_count),
		.xfer_length  (xfer_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chunk_address(chunk_address),
		.chunk_length (chunk_length),
		.total_done   (total_done),
		.last_chunk   (last_chunk)
	);

	always #10 clk = ~clk;

	walk_req_t pending[$];
	chunk_t    chunks_due[$];
	walk_req_t cur_req;
	int        mismatches = 0;
	int        send_wait = 0, send_calm = 0;
	int        recv_wait = 0, recv_calm = 0;
	int        quiet = 0;

	// Predicted table and cursor.
	logic [63:0] tbl_addr[sgcw_pkg::MAX_SEGMENTS];
	logic [31:0] tbl_len[sgcw_pkg::MAX_SEGMENTS];
	int          seg_total = 0;
	int          cur_idx = 0;
	logic [63:0] cur_addr = '0;
	logic [31:0] seg_left = '0;

	function automatic void point_cursor(int idx);
		cur_idx = idx;
		if (idx < seg_total && idx < sgcw_pkg::MAX_SEGMENTS) begin
			cur_addr = tbl_addr[idx];
			seg_left = tbl_len[idx];
		end else begin
			cur_addr = '0;
			seg_left = '0;
		end
	endfunction

	function automatic void apply_request(walk_req_t r);
		logic [31:0] remaining;
		logic [31:0] total;
		logic [31:0] piece;
		int          n;
		chunk_t      c;
		case (r.kind)
			sgcw_pkg::REQ_LOAD: begin
				tbl_addr[r.idx] = r.addr;
				tbl_len[r.idx] = r.len;
			end
			sgcw_pkg::REQ_INIT: begin
				seg_total = (r.cnt > sgcw_pkg::MAX_SEGMENTS) ? sgcw_pkg::MAX_SEGMENTS
					: int'(r.cnt);
				point_cursor(0);
			end
			sgcw_pkg::REQ_XFER: begin
				remaining = r.xlen;
				total = '0;
				n = 0;
				while (remaining != 0 && n < sgcw_pkg::RESULT_CAP) begin
					piece = (remaining < seg_left) ? remaining : seg_left;
					// A zero-length piece skips its segment and ends this request.
					if (piece == 0) begin
						if (cur_idx < seg_total)
							point_cursor(cur_idx + 1);
						break;
					end
					total += piece;
					remaining -= piece;
					c = '{cur_addr, piece, total, 1'b0};
					chunks_due.push_back(c);
					n++;
					seg_left -= piece;
					if (seg_left == 0)
						point_cursor(cur_idx + 1);
					else
						cur_addr += {32'd0, piece};
				end
				if (n == 0) begin
					c = '{cur_addr, 32'd0, 32'd0, 1'b1};
					chunks_due.push_back(c);
				end else begin
					chunks_due[chunks_due.size() - 1].last = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// Wait draw with occasional stretches of back-to-back traffic.
	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm_left = $urandom_range(10, 30);
		return $urandom_range(0, 11);
	endfunction

	function automatic walk_req_t noise_req(logic [1:0] kind);
		walk_req_t r;
		r.kind = kind;
		r.idx = 4'($urandom_range(0, 15));
		r.addr = {$urandom, $urandom};
		r.len = $urandom;
		r.cnt = 5'($urandom_range(0, 31));
		r.xlen = $urandom;
		r.hold = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				apply_request(cur_req);
				send_wait = draw_wait(send_calm);
			end
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (pending.size() != 0 &&
						!(pending[0].hold && chunks_due.size() != 0)) begin
					cur_req = pending.pop_front();
					req_type <= cur_req.kind;
					seg_index <= cur_req.idx;
					seg_address <= cur_req.addr;
					seg_length <= cur_req.len;
					seg_count <= cur_req.cnt;
					xfer_length <= cur_req.xlen;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		chunk_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (chunks_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected chunk: addr=%h len=%h total=%h last=%b",
							chunk_address, chunk_length, total_done, last_chunk);
				end else begin
					want = chunks_due.pop_front();
					if (chunk_address !== want.addr || chunk_length !== want.len ||
							total_done !== want.total || last_chunk !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("chunk mismatch: expected addr=%h len=%h total=%h last=%b",
								want.addr, want.len, want.total, want.last);
							$display("                got      addr=%h len=%h total=%h last=%b",
								chunk_address, chunk_length, total_done, last_chunk);
						end
					end
				end
				recv_wait = draw_wait(recv_calm);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL scatter_gather_chunk_walker_top");
			$finish;
		end
	end

	initial begin : stimulus
		walk_req_t   r;
		int          issued;
		int          prog;
		int          nseg;
		int          ntx;
		bit          big;
		logic [63:0] d_addr[4];
		logic [31:0] d_len[4];
		logic [31:0] d_xfer[6];

		// Directed: empty list, zero request, address wrap, zero-length
		// segment, full-width lengths and running off the end of the list.
		d_addr = '{64'hFFFF_FFFF_FFFF_FFF0, 64'h0000_0000_0000_1000,
			64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000};
		d_len = '{32'h0000_0040, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
		d_xfer = '{32'd0, 32'd8, 32'h100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5};

		r = noise_req(sgcw_pkg::REQ_XFER);
		r.xlen = 32'd100;
		pending.push_back(r);
		pending.push_back(noise_req(REQ_UNUSED));
		r = noise_req(sgcw_pkg::REQ_INIT);
		r.cnt = 5'd0;
		pending.push_back(r);
		r = noise_req(sgcw_pkg::REQ_XFER);
		r.xlen = 32'd0;
		pending.push_back(r);
		for (int i = 0; i < 4; i++) begin
			r = noise_req(sgcw_pkg::REQ_LOAD);
			r.idx = 4'(i);
			r.addr = d_addr[i];
			r.len = d_len[i];
			pending.push_back(r);
		end
		r = noise_req(sgcw_pkg::REQ_INIT);
		r.cnt = 5'd4;
		pending.push_back(r);
		for (int i = 0; i < 6; i++) begin
			r = noise_req(sgcw_pkg::REQ_XFER);
			r.xlen = d_xfer[i];
			pending.push_back(r);
		end

		// Random programs: load a list, init the cursor, then walk it.
		// The first one fills all 16 entries and hits the chunk cap.
		issued = 0;
		prog = 0;
		while (issued < 160) begin
			big = (prog == 0) || ($urandom_range(0, 7) == 0);
			nseg = big ? sgcw_pkg::MAX_SEGMENTS : $urandom_range(1, 5);
			for (int i = 0; i < nseg; i++) begin
				r = noise_req(sgcw_pkg::REQ_LOAD);
				r.idx = 4'(i);
				if ($urandom_range(0, 7) == 0)
					r.addr = {56'hFF_FFFF_FFFF_FFFF, 8'($urandom)};
				if (prog == 0)
					r.len = $urandom_range(1, 64);
				else
					case ($urandom_range(0, 9))
						0: r.len = 32'd0;
						1: ;
						default: r.len = $urandom_range(1, 64);
					endcase
				r.hold = (prog == 0 && i == 0);
				pending.push_back(r);
				issued++;
			end
			r = noise_req(sgcw_pkg::REQ_INIT);
			if (prog == 0)
				r.cnt = 5'd31;
			else if (big && $urandom_range(0, 1) == 1)
				r.cnt = 5'($urandom_range(16, 31));
			else if ($urandom_range(0, 5) == 0)
				r.cnt = 5'($urandom_range(0, nseg));
			else
				r.cnt = 5'(nseg);
			pending.push_back(r);
			issued++;
			ntx = (prog == 0) ? 2 : $urandom_range(1, 6);
			for (int j = 0; j < ntx; j++) begin
				if ($urandom_range(0, 7) == 0)
					pending.push_back(noise_req(REQ_UNUSED));
				if ($urandom_range(0, 11) == 0) begin
					pending.push_back(noise_req(sgcw_pkg::REQ_LOAD));
					issued++;
				end
				if (prog != 0 && $urandom_range(0, 15) == 0) begin
					r = noise_req(sgcw_pkg::REQ_INIT);
					r.cnt = 5'($urandom_range(0, nseg));
					pending.push_back(r);
					issued++;
				end
				r = noise_req(sgcw_pkg::REQ_XFER);
				if (prog == 0 && j == 0)
					r.xlen = 32'hFFFF_FFFF;
				else
					case ($urandom_range(0, 9))
						0: r.xlen = 32'd0;
						1: r.xlen = 32'hFFFF_FFFF;
						2: ;
						default: r.xlen = $urandom_range(1, 80);
					endcase
				r.hold = ($urandom_range(0, 19) == 0);
				pending.push_back(r);
				issued++;
			end
			prog++;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || in_valid)
			@(posedge clk);
		while (chunks_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (chunks_due.size() != 0)
			$display("%0d expected chunks never arrived", chunks_due.size());
		if (mismatches == 0 && chunks_due.size() == 0) begin
			$display("PASS scatter_gather_chunk_walker_top");
		end else begin
			$display("FAIL scatter_gather_chunk_walker_top");
		end
		$finish;
	end

endmodule
